@@ src/signed_int_to_decimal_ascii_assert.svh @@
// Assertion macros for the signed integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Checked only while out of reset.
`define SIDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SIDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sida_pkg.sv @@
// Shared constants, types and sizing function for the decimal text block.
package sida_pkg;

    localparam int VALUE_WIDTH = 32;

    function automatic int dec_digits(input int bits);
        logic [67:0] lim;
        logic [67:0] p;
        int          n;
        lim = 68'd1 << (bits - 1);
        p   = 68'd1;
        n   = 0;
        for (int i = 0; i < 24; i++)
        begin
            if (p <= lim)
            begin
                p = p * 68'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int DIGITS  = dec_digits(VALUE_WIDTH);
    localparam int DIGIT_W = 4;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int CODE_W  = 6;

    localparam logic [CODE_W-1:0] MINUS_CODE = 6'd45;
    localparam logic [CODE_W-1:0] ZERO_CODE  = 6'd48;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } bcd_res_t;

endpackage

@@ src/sida_bcd.sv @@
// Binary to BCD converter: one shift-and-adjust step per cycle.
module sida_bcd (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic [sida_pkg::VALUE_WIDTH-1:0]   value,
    output sida_pkg::bcd_res_t                 res
);

    logic [sida_pkg::VALUE_WIDTH-1:0] bin_reg;
    logic [sida_pkg::BCD_W-1:0]       bcd_reg;
    logic [sida_pkg::CNT_W-1:0]       cnt_reg;
    logic                             active_reg;
    logic                             done_reg;
    logic                             neg_reg;

    logic [sida_pkg::VALUE_WIDTH-1:0] mag;
    logic [sida_pkg::BCD_W-1:0]       adj;
    logic [sida_pkg::BCD_W-1:0]       bcd_next;
    logic [sida_pkg::VALUE_WIDTH-1:0] bin_next;

    // most negative value wraps to 2^(W-1), which is its true magnitude
    assign mag = value[sida_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    always_comb
    begin
        for (int i = 0; i < sida_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] >= 4'd5)
            begin
                adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                    bcd_reg[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                adj[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] =
                    bcd_reg[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W];
            end
        end
    end

    assign bcd_next = {adj[sida_pkg::BCD_W-2:0], bin_reg[sida_pkg::VALUE_WIDTH-1]};
    assign bin_next = {bin_reg[sida_pkg::VALUE_WIDTH-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg    <= '0;
            bcd_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go && !active_reg)
            begin
                bin_reg    <= mag;
                bcd_reg    <= '0;
                cnt_reg    <= sida_pkg::CNT_W'(sida_pkg::VALUE_WIDTH);
                neg_reg    <= value[sida_pkg::VALUE_WIDTH-1];
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                bin_reg <= bin_next;
                bcd_reg <= bcd_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == sida_pkg::CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res.done = done_reg;
        res.neg  = neg_reg;
        res.bcd  = bcd_reg;
    end

endmodule

@@ src/sida_emit.sv @@
// Character emitter: sign, then digits from the most significant nonzero one.
module sida_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  sida_pkg::bcd_res_t            res,
    output logic                          done,
    output logic                          strobe,
    output logic [sida_pkg::CODE_W-1:0]   char_code,
    output logic                          last
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SIGN,
        E_DIGIT
    } emit_state_t;

    emit_state_t                  state_reg;
    logic [sida_pkg::BCD_W-1:0]   bcd_reg;
    logic [sida_pkg::IDX_W-1:0]   idx_reg;
    logic                         strobe_reg;
    logic [sida_pkg::CODE_W-1:0]  char_reg;
    logic                         last_reg;

    logic [sida_pkg::IDX_W-1:0]   msd;
    logic [sida_pkg::DIGIT_W-1:0] digit;

    // highest nonzero digit, or the units digit for zero
    always_comb
    begin
        msd = '0;
        for (int i = 0; i < sida_pkg::DIGITS; i++)
        begin
            if (res.bcd[i*sida_pkg::DIGIT_W +: sida_pkg::DIGIT_W] != '0)
            begin
                msd = sida_pkg::IDX_W'(i);
            end
        end
    end

    assign digit = bcd_reg[{idx_reg, 2'b00} +: sida_pkg::DIGIT_W];
    assign done  = (state_reg == E_DIGIT) && (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            bcd_reg    <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                E_IDLE:
                begin
                    strobe_reg <= 1'b0;
                    last_reg   <= 1'b0;
                    if (go)
                    begin
                        bcd_reg   <= res.bcd;
                        idx_reg   <= msd;
                        state_reg <= res.neg ? E_SIGN : E_DIGIT;
                    end
                end
                E_SIGN:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= sida_pkg::MINUS_CODE;
                    last_reg   <= 1'b0;
                    state_reg  <= E_DIGIT;
                end
                E_DIGIT:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= sida_pkg::ZERO_CODE + {2'b00, digit};
                    last_reg   <= (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_reg <= E_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg  <= E_IDLE;
                    strobe_reg <= 1'b0;
                    last_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

@@ src/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII text, one character per strobe.
// Conversion runs one double-dabble step per cycle, VALUE_WIDTH steps (32 here).
// The first character is registered by the emitter once conversion is done and the emitter has taken the result.
// busy stays high while a number is converted and emitted, and falls as the last character is shown.
// Characters come one per cycle and cannot be stalled by the receiver.
// Asynchronous active-low reset returns to idle with the strobe low.
module signed_int_to_decimal_ascii (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sida_pkg::VALUE_WIDTH-1:0]   value,
    output logic                               strobe,
    output logic [sida_pkg::CODE_W-1:0]        char_code,
    output logic                               last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    sida_pkg::bcd_res_t conv_res;
    logic               go_conv;
    logic               go_emit;
    logic               emit_done;

    assign busy    = (state_reg != ST_IDLE);
    assign go_conv = start && !busy;
    assign go_emit = (state_reg == ST_CONV) && conv_res.done;

    sida_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_conv),
        .value (value),
        .res   (conv_res)
    );

    sida_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go_emit),
        .res       (conv_res),
        .done      (emit_done),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (go_conv)
                    begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    if (conv_res.done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/sida_checker.sv @@
// Port-level checker for the decimal text block, bound to the top level.
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [sida_pkg::VALUE_WIDTH-1:0]   value,
    input logic                               strobe,
    input logic [sida_pkg::CODE_W-1:0]        char_code,
    input logic                               last
);

    logic unused_value;
    assign unused_value = ^value;

    `SIDA_ASSERT(a_code_legal, strobe |-> (char_code == sida_pkg::MINUS_CODE) || ((char_code >= sida_pkg::ZERO_CODE) && (char_code <= sida_pkg::ZERO_CODE + 6'd9)), "illegal character code")
    `SIDA_ASSERT(a_sign_then_digit, strobe && (char_code == sida_pkg::MINUS_CODE) |=> strobe && !last && (char_code != sida_pkg::MINUS_CODE) || strobe && last && (char_code != sida_pkg::MINUS_CODE), "minus sign not followed by a digit")
    `SIDA_ASSERT(a_no_gap, strobe && !last |=> strobe, "gap inside a number")
    `SIDA_ASSERT(a_idle_only_last, strobe && !busy |-> last && (start == start), "non-final word shown while idle")
    `SIDA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !strobe && !busy, "activity during reset")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
);
